[rtl/crt_pkg.sv]
// Shared types, constants and state codes for the Catmull-Rom tessellator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package crt_pkg;

  // Default coordinate width (signed fixed point, Q16.16 at 32 bits)
  localparam int COORD_WIDTH_DEF = 32;

  // Span length register and span index
  localparam int SEG_W = 5;
  localparam int K_W = SEG_W;
  localparam logic [SEG_W-1:0] SEG_RESET = 5'd8;
  localparam logic [SEG_W-1:0] SEG_MIN = 5'd2;

  // Weights are bounded by 2*S^3 < 2^16 for S < 32: signed 17 bits.
  localparam int WGT_W = 17;
  // Divisor 2*S^3
  localparam int DEN_W = 16;

  typedef logic signed [WGT_W-1:0] wgt_t;

  typedef struct packed {
    wgt_t [3:0] w;
    logic [DEN_W-1:0] den;
  } wgt_set_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W_GO,
    ST_W_WAIT,
    ST_A_GO,
    ST_A_WAIT,
    ST_PUT,
    ST_END
  } seq_state_t;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_LAST,
    AR_BIAS,
    AR_DIV,
    AR_DONE
  } arith_state_t;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_t;

  typedef enum logic {
    SPAN_MAIN,
    SPAN_CLOSE
  } span_t;

endpackage

[rtl/crt_weights.sv]
// Basis weight generator: four Catmull-Rom weights for t = k/S and divisor 2*S^3.
// Depends on crt_pkg; three registered stages of narrow multiplies.
`timescale 1ns / 1ps

module crt_weights (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [crt_pkg::SEG_W-1:0] seg,
  input  logic [crt_pkg::K_W-1:0]   k,
  output crt_pkg::wgt_set_t        wgt,
  output logic                     done
);
  import crt_pkg::*;

  localparam int SQ_W = 2 * K_W;          // k^2, k*(S-k), S^2
  localparam int B_W = 8;                 // 5S - 3k, at most 155
  localparam int CU_W = SQ_W + K_W;       // cubic terms
  localparam int T_W = SQ_W + B_W;        // k^2 * (5S - 3k)

  logic v1_r, v2_r, v3_r;

  logic [K_W-1:0]  a1_r, s1_r;
  logic [SQ_W-1:0] k2_r, ka_r, s2_r;
  logic [B_W-1:0]  b_r;

  logic [CU_W-1:0] kaa_r, k2a_r, s3_r;
  logic [T_W-1:0]  t1_r;

  wgt_set_t wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: a = S - k, k^2, k*a, S^2, 5S - 3k
  always_ff @(posedge clk) begin
    a1_r <= seg - k;
    s1_r <= seg;
    k2_r <= SQ_W'(k) * SQ_W'(k);
    ka_r <= SQ_W'(k) * SQ_W'(seg - k);
    s2_r <= SQ_W'(seg) * SQ_W'(seg);
    b_r  <= B_W'(seg) * B_W'(5) - B_W'(k) * B_W'(3);
  end

  // Stage 2: k*a^2, k^2*a, k^2*(5S - 3k), S^3
  always_ff @(posedge clk) begin
    kaa_r <= CU_W'(ka_r) * CU_W'(a1_r);
    k2a_r <= CU_W'(k2_r) * CU_W'(a1_r);
    t1_r  <= T_W'(k2_r) * T_W'(b_r);
    s3_r  <= CU_W'(s2_r) * CU_W'(s1_r);
  end

  // Stage 3: W0 = -k*a^2, W3 = -k^2*a, W1 = 2S^3 - t1, W2 = t1 + k*a^2 + k^2*a
  always_ff @(posedge clk) begin
    wgt_r.w[0] <= -$signed({2'b00, kaa_r});
    wgt_r.w[3] <= -$signed({2'b00, k2a_r});
    wgt_r.w[1] <= $signed({1'b0, s3_r, 1'b0}) - $signed(t1_r[WGT_W-1:0]);
    wgt_r.w[2] <= $signed(t1_r[WGT_W-1:0] + {2'b00, kaa_r} + {2'b00, k2a_r});
    wgt_r.den  <= {s3_r, 1'b0};
  end

  assign wgt  = wgt_r;
  assign done = v3_r;

endmodule

[rtl/crt_arith.sv]
// Shared arithmetic unit: four-term multiply-accumulate, then a restoring
// divide by 2*S^3 with round-to-nearest and saturation. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_arith #(
  parameter int COORD_WIDTH = crt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [3:0][COORD_WIDTH-1:0]   pts,
  input  crt_pkg::wgt_set_t             wgt,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] q
);
  import crt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + WGT_W;
  localparam int AW = CW + DEN_W + 1;
  localparam int QW = CW + 1;
  localparam int BW = $clog2(QW);

  arith_state_t state_r, state_nxt;

  logic [1:0]            idx_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [AW-1:0]  acc_r;
  logic [AW-1:0]         rem_r, dsr_r;
  logic [QW-1:0]         quo_r;
  logic [BW-1:0]         bit_r;

  logic signed [CW-1:0]  p_sel;
  wgt_t                  w_sel;
  logic                  ge;
  logic [QW-1:0]         qs;

  assign p_sel = $signed(pts[idx_r]);
  assign w_sel = $signed(wgt.w[idx_r]);
  assign ge    = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    case (state_r)
      AR_IDLE: begin
        if (start) state_nxt = AR_MUL;
      end
      AR_MUL: begin
        if (idx_r == 2'd3) state_nxt = AR_LAST;
      end
      AR_LAST: state_nxt = AR_BIAS;
      AR_BIAS: state_nxt = AR_DIV;
      AR_DIV: begin
        if (bit_r == '0) state_nxt = AR_DONE;
      end
      AR_DONE: begin
        done      = 1'b1;
        state_nxt = AR_IDLE;
      end
      default: state_nxt = AR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      AR_IDLE: begin
        idx_r <= 2'd0;
        // Seed with S^3 for round to nearest
        acc_r <= AW'(wgt.den >> 1);
      end
      AR_MUL: begin
        prod_r <= PW'(p_sel) * PW'(w_sel);
        if (idx_r != 2'd0) acc_r <= acc_r + AW'(prod_r);
        idx_r <= idx_r + 2'd1;
      end
      AR_LAST: begin
        acc_r <= acc_r + AW'(prod_r);
      end
      AR_BIAS: begin
        // Offset by den * 2^CW so the dividend is never negative
        rem_r <= $unsigned(acc_r) + (AW'(wgt.den) << CW);
        dsr_r <= AW'(wgt.den) << CW;
        bit_r <= BW'(QW - 1);
        quo_r <= '0;
      end
      AR_DIV: begin
        if (ge) rem_r <= rem_r - dsr_r;
        quo_r <= {quo_r[QW-2:0], ge};
        dsr_r <= dsr_r >> 1;
        bit_r <= bit_r - BW'(1);
      end
      default: begin
      end
    endcase
  end

  // Remove the offset by flipping the top quotient bit, then saturate
  always_comb begin
    qs = {~quo_r[QW-1], quo_r[QW-2:0]};
    if (qs[CW] != qs[CW-1]) begin
      q = qs[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      q = qs[CW-1:0];
    end
  end

endmodule

[rtl/catmull_rom_tessellator.sv]
// Catmull-Rom tessellator top: window, sequencer, output register. Uses crt_pkg.
// A control point that yields no curve point is only taken in. Each curve point
// is made from weights, then x and y one after the other through the shared
// multiply-accumulate and 1-bit-per-cycle divider.
// An item yields up to 2*S+1 points. Sync active-low reset clears sequencer,
// point count, output valid and sets segments_per_span to 8; window not cleared.
`timescale 1ns / 1ps

module catmull_rom_tessellator #(
  parameter int COORD_WIDTH = crt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [crt_pkg::SEG_W-1:0]     cfg_wdata,
  // control point beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_final_point,
  // curve point beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_curve_x,
  output logic signed [COORD_WIDTH-1:0] out_curve_y,
  output logic                          out_end_of_run,
  output logic                          out_end_of_curve
);
  import crt_pkg::*;

  localparam int CW = COORD_WIDTH;

  seq_state_t state_r, state_nxt;

  logic [SEG_W-1:0] seg_r;
  logic [SEG_W-1:0] seg_eff;
  logic [1:0]       cnt_r;
  logic [K_W-1:0]   k_r;
  axis_t            axis_r;
  span_t            span_r;
  logic             fin_r;

  // Window, oldest first, plus the entry shifted out by the last beat
  logic signed [CW-1:0] wx_r [0:2];
  logic signed [CW-1:0] wy_r [0:2];
  logic signed [CW-1:0] wox_r, woy_r;

  logic signed [CW-1:0] rx_r, ry_r;

  logic             out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic             out_eor_r, out_eoc_r;

  // sequencer strobes
  logic accept, wgt_start, ar_start, cap_x, cap_y, out_load, load_end;
  logic k_last, out_free;

  wgt_set_t wgt;
  logic     wgt_done;
  logic     ar_done;
  logic signed [CW-1:0] ar_q;
  logic [3:0][CW-1:0]   pts;

  // Values below two act as two
  assign seg_eff  = (seg_r < SEG_MIN) ? SEG_MIN : seg_r;
  assign k_last   = (k_r == seg_eff - SEG_W'(1));
  assign out_free = !out_valid_r || out_ready;

  // Pick the four control points for the span and axis in progress
  always_comb begin
    if (axis_r == AXIS_X) begin
      if (span_r == SPAN_MAIN) begin
        pts = {wx_r[2], wx_r[1], wx_r[0], wox_r};
      end else begin
        pts = {wx_r[2], wx_r[2], wx_r[1], wx_r[0]};
      end
    end else begin
      if (span_r == SPAN_MAIN) begin
        pts = {wy_r[2], wy_r[1], wy_r[0], woy_r};
      end else begin
        pts = {wy_r[2], wy_r[2], wy_r[1], wy_r[0]};
      end
    end
  end

  crt_weights u_weights (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wgt_start),
    .seg   (seg_eff),
    .k     (k_r),
    .wgt   (wgt),
    .done  (wgt_done)
  );

  crt_arith #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ar_start),
    .pts   (pts),
    .wgt   (wgt),
    .done  (ar_done),
    .q     (ar_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    wgt_start = 1'b0;
    ar_start  = 1'b0;
    cap_x     = 1'b0;
    cap_y     = 1'b0;
    out_load  = 1'b0;
    load_end  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept = 1'b1;
          if (cnt_r >= 2'd2) begin
            state_nxt = ST_W_GO;
          end else if (in_final_point && cnt_r != 2'd0) begin
            state_nxt = ST_W_GO;
          end else if (in_final_point) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_W_GO: begin
        wgt_start = 1'b1;
        state_nxt = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        if (wgt_done) state_nxt = ST_A_GO;
      end
      ST_A_GO: begin
        ar_start  = 1'b1;
        state_nxt = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        if (ar_done) begin
          if (axis_r == AXIS_X) begin
            cap_x     = 1'b1;
            state_nxt = ST_A_GO;
          end else begin
            cap_y     = 1'b1;
            state_nxt = ST_PUT;
          end
        end
      end
      ST_PUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!k_last) begin
            state_nxt = ST_W_GO;
          end else if (span_r == SPAN_MAIN && !fin_r) begin
            state_nxt = ST_IDLE;
          end else if (span_r == SPAN_MAIN) begin
            state_nxt = ST_W_GO;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_end  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration and sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= SEG_RESET;
      cnt_r  <= 2'd0;
      k_r    <= '0;
      axis_r <= AXIS_X;
      span_r <= SPAN_MAIN;
      fin_r  <= 1'b0;
    end else begin
      if (cfg_we) seg_r <= cfg_wdata;
      if (accept) begin
        fin_r  <= in_final_point;
        k_r    <= '0;
        span_r <= (cnt_r >= 2'd2) ? SPAN_MAIN : SPAN_CLOSE;
        // Drop the count on the final point, saturate at three otherwise
        if (in_final_point) begin
          cnt_r <= 2'd0;
        end else if (cnt_r != 2'd3) begin
          cnt_r <= cnt_r + 2'd1;
        end
      end
      if (wgt_done) axis_r <= AXIS_X;
      if (cap_x) axis_r <= AXIS_Y;
      if (out_load && !load_end) begin
        if (k_last) begin
          // Main span of a final point hands over to the closing span
          k_r    <= '0;
          span_r <= SPAN_CLOSE;
        end else begin
          k_r <= k_r + K_W'(1);
        end
      end
    end
  end

  // Window: the first point of a spline fills every entry, later points shift in
  always_ff @(posedge clk) begin
    if (accept) begin
      wox_r <= wx_r[0];
      woy_r <= wy_r[0];
      if (cnt_r == 2'd0) begin
        wx_r[0] <= in_point_x;
        wx_r[1] <= in_point_x;
        wy_r[0] <= in_point_y;
        wy_r[1] <= in_point_y;
      end else begin
        wx_r[0] <= wx_r[1];
        wx_r[1] <= wx_r[2];
        wy_r[0] <= wy_r[1];
        wy_r[1] <= wy_r[2];
      end
      wx_r[2] <= in_point_x;
      wy_r[2] <= in_point_y;
    end
  end

  // Hold the x result while y runs through the shared unit
  always_ff @(posedge clk) begin
    if (cap_x) rx_r <= ar_q;
    if (cap_y) ry_r <= ar_q;
  end

  // Output register: a finished point waits here while the next one is worked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (load_end) begin
        // Final endpoint of the spline closes the run and the curve
        out_x_r   <= wx_r[2];
        out_y_r   <= wy_r[2];
        out_eor_r <= 1'b1;
        out_eoc_r <= 1'b1;
      end else begin
        out_x_r   <= rx_r;
        out_y_r   <= ry_r;
        out_eor_r <= k_last && !fin_r;
        out_eoc_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_curve_x      = out_x_r;
  assign out_curve_y      = out_y_r;
  assign out_end_of_run   = out_eor_r;
  assign out_end_of_curve = out_eoc_r;

endmodule
